@@ sv/mep_pkg.sv @@
package mep_pkg;

  // Fixed widths of the pixel, register and arithmetic fields.
  localparam int WORD_W = 32;  // signed fixed-point container
  localparam int COL_W  = 13;  // pixel column and row
  localparam int ORG_W  = 12;  // window origin
  localparam int DEN_W  = 13;  // window dimension, also the divisor width
  localparam int NUM_W  = 17;  // integer part of a dividend
  localparam int ITER_W = 8;   // iteration count and colour
  localparam int CH_W   = 2;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_W  = 3;

  localparam logic signed [63:0] WORD_MAX = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
  localparam logic signed [63:0] WORD_MIN = -(64'sd1 <<< (WORD_W - 1));

  localparam int MAX_DIM_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 28;

  // Register indexes on the configuration port.
  localparam logic [REG_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_W-1:0] REG_WIDTH    = 3'd2;
  localparam logic [REG_W-1:0] REG_HEIGHT   = 3'd3;
  localparam logic [REG_W-1:0] REG_CHANNEL  = 3'd4;
  localparam logic [REG_W-1:0] REG_MAX_ITER = 3'd5;

  // Colour channel codes.
  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
  localparam logic [CH_W-1:0] CH_BLACK = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0] pixel_col;
    logic [COL_W-1:0] pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [COL_W-1:0]  out_col;
    logic [COL_W-1:0]  out_row;
    logic [ITER_W-1:0] red;
    logic [ITER_W-1:0] green;
    logic [ITER_W-1:0] blue;
    logic [ITER_W-1:0] escape_count;
  } pix_out_t;

  typedef struct packed {
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
    logic [DEN_W-1:0]  width;
    logic [DEN_W-1:0]  height;
    logic [CH_W-1:0]   channel;
    logic [ITER_W-1:0] max_iterations;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_pixel;
    logic div_step;
    logic map_load;
    logic iter_step;
    logic mul;
    logic color_load;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic iter_go;
    logic need_color;
  } status_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
    logic signed [WORD_W-1:0] res;
    if (v > WORD_MAX) begin
      res = WORD_MAX[WORD_W-1:0];
    end else if (v < WORD_MIN) begin
      res = WORD_MIN[WORD_W-1:0];
    end else begin
      res = v[WORD_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [63:0] wext(input logic signed [WORD_W-1:0] x);
    return {{(64 - WORD_W){x[WORD_W-1]}}, x};
  endfunction

  function automatic logic [DEN_W-1:0] clamp_dim(input logic [DEN_W-1:0] d,
                                                 input logic [DEN_W-1:0] dmax);
    logic [DEN_W-1:0] res;
    if (d == '0) begin
      res = DEN_W'(1);
    end else if (d > dmax) begin
      res = dmax;
    end else begin
      res = d;
    end
    return res;
  endfunction

endpackage

@@ sv/mep_divlane.sv @@
module mep_divlane
  import mep_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [WORD_W-1:0] quo,
  output logic              ovf
);

  // Restoring divider, one quotient bit per step. The dividend is the
  // integer part followed by as many zero bits as further steps are run.
  // Bits pushed off the top of the quotient set a sticky overflow flag.

  logic [NUM_W-1:0]  m_r, m_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  d_r;
  logic [WORD_W-1:0] q_r, q_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              take;

  always_comb begin
    trial   = {rem_r, m_r[NUM_W-1]};
    diff    = trial - {1'b0, d_r};
    take    = (trial >= {1'b0, d_r});
    rem_nxt = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    m_nxt   = {m_r[NUM_W-2:0], 1'b0};
    q_nxt   = {q_r[WORD_W-2:0], take};
    ovf_nxt = ovf_r | q_r[WORD_W-1];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_r   <= num;
      rem_r <= '0;
      d_r   <= den;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (step) begin
      m_r   <= m_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign quo = q_r;
  assign ovf = ovf_r;

endmodule

@@ sv/mep_datapath.sv @@
module mep_datapath
  import mep_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  cmd_t     cmd,
  input  pix_in_t  in_pixel,
  input  cfg_t     cfg,
  output status_t  status,
  output pix_out_t result
);

  localparam logic signed [63:0] ONE_Q      = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] TWO_HALF_Q = 64'sd5 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] FOUR_Q     = 64'sd1 <<< (FRAC_BITS + 2);

  pix_in_t                  pix_r;
  logic                     neg_x_r, neg_y_r;
  logic signed [WORD_W-1:0] x0_r, y0_r, px_r, py_r;
  logic signed [63:0]       pxx_r, pyy_r, pxy_r;
  logic [ITER_W-1:0]        iter_r;
  pix_out_t                 res_r;

  logic signed [COL_W:0]    off_x, off_y, neg_off_x, neg_off_y;
  logic [COL_W-1:0]         abs_x, abs_y;
  logic [NUM_W-1:0]         num_x, num_y, num_c, lane_x_num;
  logic [DEN_W-1:0]         lane_x_den;
  logic                     lane_x_load;
  logic [WORD_W-1:0]        quo_x, quo_y;
  logic                     ovf_x, ovf_y;
  logic signed [WORD_W-1:0] map_x, map_y;
  logic signed [WORD_W-1:0] mxy, x2, y2;
  logic signed [63:0]       sum_sq;
  logic signed [WORD_W-1:0] px_nxt, py_nxt;
  logic [ITER_W-1:0]        val;
  pix_out_t                 res_nxt;

  // Applies the offset's sign to the quotient magnitude, with saturation.
  function automatic logic signed [WORD_W-1:0] map_word(input logic neg,
                                                        input logic [WORD_W-1:0] q,
                                                        input logic ovf);
    logic                     over;
    logic signed [WORD_W-1:0] res;
    over = ovf | q[WORD_W-1];
    if (neg) begin
      res = over ? WORD_MIN[WORD_W-1:0] : -$signed(q);
    end else begin
      res = over ? WORD_MAX[WORD_W-1:0] : $signed(q);
    end
    return res;
  endfunction

  // Pixel offsets from the window origin, split into sign and magnitude.
  always_comb begin
    off_x     = $signed({1'b0, in_pixel.pixel_col}) - $signed({2'b00, cfg.origin_x});
    off_y     = $signed({1'b0, in_pixel.pixel_row}) - $signed({2'b00, cfg.origin_y});
    neg_off_x = -off_x;
    neg_off_y = -off_y;
    abs_x     = off_x[COL_W] ? neg_off_x[COL_W-1:0] : off_x[COL_W-1:0];
    abs_y     = off_y[COL_W] ? neg_off_y[COL_W-1:0] : off_y[COL_W-1:0];
    // Real axis scales by 7 over one step fewer, imaginary by 4 (2 * 2).
    num_x     = (NUM_W'(abs_x) << 3) - NUM_W'(abs_x);
    num_y     = NUM_W'(abs_y) << 2;
    num_c     = (NUM_W'(iter_r) << ITER_W) - NUM_W'(iter_r);
    lane_x_load = cmd.load_pixel | cmd.color_load;
    lane_x_num  = cmd.color_load ? num_c : num_x;
    lane_x_den  = cmd.color_load ? DEN_W'(cfg.max_iterations)
                                 : clamp_dim(cfg.width, DEN_W'(MAX_DIM));
  end

  mep_divlane u_div_x (
    .clk  (clk),
    .load (lane_x_load),
    .step (cmd.div_step),
    .num  (lane_x_num),
    .den  (lane_x_den),
    .quo  (quo_x),
    .ovf  (ovf_x)
  );

  mep_divlane u_div_y (
    .clk  (clk),
    .load (cmd.load_pixel),
    .step (cmd.div_step),
    .num  (num_y),
    .den  (clamp_dim(cfg.height, DEN_W'(MAX_DIM))),
    .quo  (quo_y),
    .ovf  (ovf_y)
  );

  // Escape iteration: products are registered, then rescaled and tested.
  always_comb begin
    map_x  = map_word(neg_x_r, quo_x, ovf_x);
    map_y  = map_word(neg_y_r, quo_y, ovf_y);
    mxy    = sat_word(pxy_r >>> FRAC_BITS);
    x2     = sat_word(pxx_r >>> FRAC_BITS);
    y2     = sat_word(pyy_r >>> FRAC_BITS);
    sum_sq = wext(x2) + wext(y2);
    py_nxt = sat_word((wext(mxy) <<< 1) + wext(y0_r));
    px_nxt = sat_word(wext(x2) - wext(y2) + wext(x0_r));
    status.iter_go    = (sum_sq <= FOUR_Q) && (iter_r < cfg.max_iterations);
    status.need_color = (cfg.max_iterations != '0) && (iter_r != cfg.max_iterations);
  end

  always_comb begin
    val = status.need_color ? quo_x[ITER_W-1:0] : '0;
    res_nxt.out_col      = pix_r.pixel_col;
    res_nxt.out_row      = pix_r.pixel_row;
    res_nxt.red          = '0;
    res_nxt.green        = '0;
    res_nxt.blue         = '0;
    res_nxt.escape_count = iter_r;
    case (cfg.channel)
      CH_RED:   res_nxt.red   = val;
      CH_GREEN: res_nxt.green = val;
      CH_BLUE:  res_nxt.blue  = val;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      pix_r   <= in_pixel;
      neg_x_r <= off_x[COL_W];
      neg_y_r <= off_y[COL_W];
    end
    if (cmd.map_load) begin
      x0_r   <= sat_word(wext(map_x) - TWO_HALF_Q);
      y0_r   <= sat_word(wext(map_y) - ONE_Q);
      px_r   <= '0;
      py_r   <= '0;
      pxx_r  <= '0;
      pyy_r  <= '0;
      pxy_r  <= '0;
      iter_r <= '0;
    end
    if (cmd.iter_step) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      iter_r <= iter_r + ITER_W'(1);
    end
    if (cmd.mul) begin
      pxx_r <= px_r * px_r;
      pyy_r <= py_r * py_r;
      pxy_r <= px_r * py_r;
    end
    if (cmd.fin) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

@@ sv/mep_ctrl.sv @@
module mep_ctrl
  import mep_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output logic    out_valid,
  output cmd_t    cmd
);

  localparam int MAP_STEPS   = 16 + FRAC_BITS;
  localparam int COLOR_STEPS = NUM_W;
  localparam int CNT_W       = $clog2(MAP_STEPS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_MAP  = 8'b0000_0100,
    S_STEP = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_CDIV = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  always_comb begin
    busy      = !((state_r == S_IDLE) || (state_r == S_OUT));
    out_valid = (state_r == S_OUT);
    accept    = start && !busy;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE, S_OUT: begin
        state_nxt = S_IDLE;
        if (accept) begin
          cmd.load_pixel = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAP_STEPS - 1)) begin
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map_load = 1'b1;
        state_nxt    = S_STEP;
      end
      S_STEP: begin
        if (status.iter_go) begin
          cmd.iter_step = 1'b1;
          state_nxt     = S_MUL;
        end else if (status.need_color) begin
          cmd.color_load = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_CDIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_STEP;
      end
      S_CDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(COLOR_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ sv/mandelbrot_escape_pixel_top.sv @@
// Channel        Direction  Handshake                         Payload
// input pixel    in         start high while busy low         in_pixel (pix_in_t)
// result         out        out_valid strobe, one cycle       out_result (pix_out_t)
// configuration  in/out     APB write: psel penable pwrite    paddr, pwdata, prdata
//
// For each pixel the bit-serial divider lanes map the pixel into the plane, the escape
// loop alternates an update and a multiply, and a colour division scales the count;
// the colour division is skipped when the limit is reached or the limit is zero.
// Reset is synchronous and active low; it clears the controller and loads the register
// defaults. The receiver cannot stall: each result is shown for exactly one cycle.
module mandelbrot_escape_pixel_top
  import mep_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input pixel channel.
  input  logic              start,
  output logic              busy,
  input  pix_in_t           in_pixel,
  // Result channel.
  output logic              out_valid,
  output pix_out_t          out_result,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t             cfg_r;
  logic             cfg_wr;
  logic [REG_W-1:0] reg_idx;
  cmd_t             cmd;
  status_t          status;

  // The register file. Registers sit on 32-bit word boundaries, so the word
  // index is the register number. Writes beyond the last register are ignored.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x       <= '0;
      cfg_r.origin_y       <= '0;
      cfg_r.width          <= DEN_W'(1024);
      cfg_r.height         <= DEN_W'(768);
      cfg_r.channel        <= CH_RED;
      cfg_r.max_iterations <= ITER_W'(35);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ORIGIN_X: cfg_r.origin_x       <= pwdata[ORG_W-1:0];
        REG_ORIGIN_Y: cfg_r.origin_y       <= pwdata[ORG_W-1:0];
        REG_WIDTH:    cfg_r.width          <= pwdata[DEN_W-1:0];
        REG_HEIGHT:   cfg_r.height         <= pwdata[DEN_W-1:0];
        REG_CHANNEL:  cfg_r.channel        <= pwdata[CH_W-1:0];
        REG_MAX_ITER: cfg_r.max_iterations <= pwdata[ITER_W-1:0];
        default:      ;
      endcase
    end
  end

  // Read data is decoded straight from the address; unused words read as zero.
  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X: prdata = DATA_W'(cfg_r.origin_x);
      REG_ORIGIN_Y: prdata = DATA_W'(cfg_r.origin_y);
      REG_WIDTH:    prdata = DATA_W'(cfg_r.width);
      REG_HEIGHT:   prdata = DATA_W'(cfg_r.height);
      REG_CHANNEL:  prdata = DATA_W'(cfg_r.channel);
      REG_MAX_ITER: prdata = DATA_W'(cfg_r.max_iterations);
      default:      prdata = '0;
    endcase
  end

  // The controller sequences mapping, iteration and colour scaling; the
  // datapath holds all pixel arithmetic and the result register. A new
  // transfer is taken in the same cycle that the previous result is shown.
  mep_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mep_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .in_pixel (in_pixel),
    .cfg      (cfg_r),
    .status   (status),
    .result   (out_result)
  );

  // Every result occupies a single cycle; the pipeline never emits two in a row.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted transfer must start the work at once.
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("accepted pixel did not make the block busy");

  // The count can never pass the programmed limit.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid |-> (out_result.escape_count <= cfg_r.max_iterations))
    else $error("escape count above the iteration limit");

  // With the black selection no colour channel may light up.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && (cfg_r.channel == CH_BLACK)) |->
                   ((out_result.red == '0) && (out_result.green == '0) &&
                    (out_result.blue == '0)))
    else $error("colour output with the black channel selected");

endmodule

@@ tb/sv/mandelbrot_escape_pixel_top_tb.sv @@
module mandelbrot_escape_pixel_top_tb;
  import mep_pkg::*;

  // Fixed-point scale of the escape loop and the constants that depend on it.
  localparam int    FRAC       = FRAC_BITS_DEF;
  localparam longint ONE_Q      = longint'(1) <<< FRAC;
  localparam longint TWO_HALF_Q = longint'(5) <<< (FRAC - 1);
  localparam longint FOUR_Q     = longint'(1) <<< (FRAC + 2);

  // Random part: phases of one window setting each.
  localparam int PHASES        = 9;
  localparam int PHASE_PIXELS  = 200;
  localparam int CALM_PHASE    = 4;     // no idling at all in this phase
  localparam int DRAIN_CYCLES  = 600;   // beyond the slowest pixel at a limit of 255

  typedef enum bit {ROW_CFG, ROW_PIX} row_kind_t;

  // One row of the directed table: either a register write or a pixel transfer.
  typedef struct {
    row_kind_t        kind;
    logic [REG_W-1:0] reg_idx;
    logic [31:0]      reg_val;
    pix_in_t          pix;
    bit               typed;
    pix_out_t         result;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  pix_in_t           in_pixel;
  logic              out_valid;
  pix_out_t          out_result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Shadow copy of the window registers, as the block should hold them.
  logic [ORG_W-1:0]  win_origin_x;
  logic [ORG_W-1:0]  win_origin_y;
  logic [DEN_W-1:0]  win_width;
  logic [DEN_W-1:0]  win_height;
  logic [CH_W-1:0]   win_channel;
  logic [ITER_W-1:0] win_max_iter;

  // Pixels accepted by the block whose results have not yet come out, oldest first.
  pix_out_t pending_pixels[$];
  int       n_errors;

  mandelbrot_escape_pixel_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_result (out_result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // A fixed ceiling on run time. The slowest legal run, every pixel at a limit of
  // 255 with the longest gaps, takes roughly an eighth of it.
  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Escape-time predictor.
  // ---------------------------------------------------------------------------

  // Clamp to the signed 32-bit range of a Q4.28 word.
  function automatic longint sat_q(input longint v);
    if (v > longint'(32'h7FFF_FFFF)) return longint'(32'h7FFF_FFFF);
    if (v < -longint'(33'h0_8000_0000)) return -longint'(33'h0_8000_0000);
    return v;
  endfunction

  // Product of two words; the arithmetic shift of a signed value rounds toward
  // minus infinity, which is the rounding the datapath uses.
  function automatic longint fx_mul(input longint a, input longint b);
    return sat_q((a * b) >>> FRAC);
  endfunction

  // Window dimensions as the divider sees them: zero acts as one, and anything
  // above the largest supported size is held at it.
  function automatic int eff_dim(input logic [DEN_W-1:0] d);
    if (d == '0) return 1;
    if (d > DEN_W'(MAX_DIM_DEF)) return MAX_DIM_DEF;
    return int'(d);
  endfunction

  // Pixel offset to plane coordinate: the magnitude |off|*k*2^s/div is formed by
  // restoring long division and truncated, then the sign of the offset is put back.
  // The quotient stops growing once it has reached 2^40, far beyond the word range.
  function automatic longint map_to_plane(input longint off, input longint unsigned k,
                                          input longint unsigned div, input int s);
    bit                neg;
    longint unsigned   n;
    longint unsigned   q;
    longint unsigned   r;
    longint unsigned   cap;
    int                i;
    cap = longint'(1) << 40;
    neg = off < 0;
    n   = longint'(neg ? -off : off) * k;
    q   = n / div;
    r   = n % div;
    for (i = 0; i < s && q < cap; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= div) begin
        r = r - div;
        q = q | 1;
      end
    end
    if (q > cap) q = cap;
    return sat_q(neg ? -longint'(q) : longint'(q));
  endfunction

  // The result the block owes for one pixel under the current window settings.
  function automatic pix_out_t compute_escape(input pix_in_t p);
    pix_out_t r;
    longint   x0;
    longint   y0;
    longint   zx;
    longint   zy;
    longint   zx2;
    longint   zy2;
    int       iter;
    int       lim;
    int       shade;
    x0 = map_to_plane(longint'(p.pixel_col) - longint'(win_origin_x), 7,
                      eff_dim(win_width), FRAC - 1);
    x0 = sat_q(x0 - TWO_HALF_Q);
    y0 = map_to_plane(longint'(p.pixel_row) - longint'(win_origin_y), 2,
                      eff_dim(win_height), FRAC);
    y0 = sat_q(y0 - ONE_Q);
    zx   = 0;
    zy   = 0;
    zx2  = 0;
    zy2  = 0;
    iter = 0;
    lim  = int'(win_max_iter);
    // The magnitude test uses the exact sum of the two squares.
    while (zx2 + zy2 <= FOUR_Q && iter < lim) begin
      zy  = sat_q(2 * fx_mul(zx, zy) + y0);
      zx  = sat_q(zx2 - zy2 + x0);
      zx2 = fx_mul(zx, zx);
      zy2 = fx_mul(zy, zy);
      iter++;
    end
    // A pixel that ran to the limit is drawn dark in the selected channel.
    shade = (lim != 0 && iter != lim) ? (iter * 255) / lim : 0;
    r.out_col      = p.pixel_col;
    r.out_row      = p.pixel_row;
    r.red          = (win_channel == CH_RED)   ? ITER_W'(shade) : '0;
    r.green        = (win_channel == CH_GREEN) ? ITER_W'(shade) : '0;
    r.blue         = (win_channel == CH_BLUE)  ? ITER_W'(shade) : '0;
    r.escape_count = ITER_W'(iter);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result monitor. The receiver cannot hold results off, so every strobe is a
  // transfer, taken at the rising edge that ends its cycle.
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("result for pixel (%0d, %0d) with no pixel outstanding",
               out_result.out_col, out_result.out_row);
        n_errors++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_col",      32'(want.out_col),      32'(out_result.out_col));
        check_field("out_row",      32'(want.out_row),      32'(out_result.out_row));
        check_field("red",          32'(want.red),          32'(out_result.red));
        check_field("green",        32'(want.green),        32'(out_result.green));
        check_field("blue",         32'(want.blue),         32'(out_result.blue));
        check_field("escape_count", 32'(want.escape_count), 32'(out_result.escape_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration port. Each access has a setup cycle and an access cycle;
  // inputs move on the falling edge and the access completes on the rising edge.
  // ---------------------------------------------------------------------------

  task automatic cfg_read(input logic [REG_W-1:0] idx, output logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write one register, mirror it in the shadow copy and read it straight back.
  task automatic cfg_write(input logic [REG_W-1:0] idx, input logic [31:0] val);
    logic [31:0] held;
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ORIGIN_X: begin
        win_origin_x = val[ORG_W-1:0];
        held = 32'(win_origin_x);
      end
      REG_ORIGIN_Y: begin
        win_origin_y = val[ORG_W-1:0];
        held = 32'(win_origin_y);
      end
      REG_WIDTH: begin
        win_width = val[DEN_W-1:0];
        held = 32'(win_width);
      end
      REG_HEIGHT: begin
        win_height = val[DEN_W-1:0];
        held = 32'(win_height);
      end
      REG_CHANNEL: begin
        win_channel = val[CH_W-1:0];
        held = 32'(win_channel);
      end
      default: begin
        win_max_iter = val[ITER_W-1:0];
        held = 32'(win_max_iter);
      end
    endcase
    cfg_read(idx, readback);
    check_field("register readback", held, readback);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel channel.
  // ---------------------------------------------------------------------------

  // Lower start so that no pixel is taken twice, then hold off until the block is
  // idle with nothing owed; registers only change here.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // One pixel transfer. While the sender waits, start is dropped at random with a
  // chance of about 16 in a hundred, so idle cycles also fall where the block is ready.
  // start stays high into the next call after a transfer, and each falling edge
  // carries a single update of it.
  task automatic send_pixel(input pix_in_t p, input pix_out_t want, input bit may_idle);
    bit sent;
    sent = 1'b0;
    while (!sent) begin
      @(negedge clk);
      start    <= !(may_idle && ($urandom_range(99) < 16));
      in_pixel <= p;
      @(posedge clk);
      sent = (start === 1'b1) && (busy === 1'b0);
    end
    pending_pixels.push_back(want);
  endtask

  function automatic dir_row_t cfg_row(input logic [REG_W-1:0] idx, input logic [31:0] val);
    dir_row_t row;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.pix     = '0;
    row.typed   = 1'b0;
    row.result  = '0;
    return row;
  endfunction

  // A pixel row; with typed set the result given is used instead of the predictor.
  function automatic dir_row_t pix_row(input int col, input int row_no, input bit typed,
                                       input pix_out_t result);
    dir_row_t row;
    row.kind    = ROW_PIX;
    row.reg_idx = REG_ORIGIN_X;
    row.reg_val = '0;
    row.pix     = '{pixel_col: COL_W'(col), pixel_row: COL_W'(row_no)};
    row.typed   = typed;
    row.result  = result;
    return row;
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'd4095;
      default: return 32'($urandom_range(4095));
    endcase
  endfunction

  // Dimensions include zero and the top of the 13-bit field, both of which the
  // block has to clamp; small windows are favoured a little.
  function automatic logic [31:0] pick_dim();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd4096;
      3:       return 32'd8191;
      4:       return 32'($urandom_range(64, 1));
      default: return 32'($urandom_range(4096, 16));
    endcase
  endfunction

  // Mostly moderate limits keep the run short; zero, one and 255 turn up now and then.
  function automatic logic [31:0] pick_limit();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd255;
      default: return 32'($urandom_range(80, 2));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t    dir_tab[$];
    logic [31:0] reset_value[6];
    logic [31:0] readback;
    pix_in_t     p;
    pix_out_t    want;
    int          i;
    int          ph;
    int          k;

    // Every input is known from time zero, and reset starts asserted.
    rst_n    = 1'b0;
    start    = 1'b0;
    in_pixel = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    n_errors = 0;

    win_origin_x = '0;
    win_origin_y = '0;
    win_width    = DEN_W'(1024);
    win_height   = DEN_W'(768);
    win_channel  = CH_RED;
    win_max_iter = ITER_W'(35);

    reset_value[REG_ORIGIN_X] = 32'd0;
    reset_value[REG_ORIGIN_Y] = 32'd0;
    reset_value[REG_WIDTH]    = 32'd1024;
    reset_value[REG_HEIGHT]   = 32'd768;
    reset_value[REG_CHANNEL]  = 32'(CH_RED);
    reset_value[REG_MAX_ITER] = 32'd35;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // The registers must come out of reset at their defaults.
    for (i = 0; i < 6; i++) begin
      cfg_read(REG_W'(i), readback);
      check_field("register after reset", reset_value[i], readback);
    end

    // Directed table. The top-left pixel of the default window is c = -2.5 - i,
    // which escapes after one step, so its shade is 255/35 = 7 in the selected
    // channel. With a limit of one, every pixel stops at the limit and is dark;
    // with a limit of zero nothing is iterated at all.
    dir_tab.push_back(pix_row(0, 0, 1'b1, '{0, 0, 7, 0, 0, 1}));
    dir_tab.push_back(pix_row(8191, 8191, 1'b0, '0));
    dir_tab.push_back(pix_row(731, 384, 1'b0, '0));
    dir_tab.push_back(pix_row(500, 300, 1'b0, '0));
    dir_tab.push_back(cfg_row(REG_CHANNEL, 32'(CH_GREEN)));
    dir_tab.push_back(pix_row(0, 0, 1'b1, '{0, 0, 0, 7, 0, 1}));
    dir_tab.push_back(cfg_row(REG_CHANNEL, 32'(CH_BLUE)));
    dir_tab.push_back(pix_row(0, 0, 1'b1, '{0, 0, 0, 0, 7, 1}));
    dir_tab.push_back(cfg_row(REG_CHANNEL, 32'(CH_BLACK)));
    dir_tab.push_back(pix_row(0, 0, 1'b1, '{0, 0, 0, 0, 0, 1}));
    dir_tab.push_back(cfg_row(REG_CHANNEL, 32'(CH_RED)));
    dir_tab.push_back(cfg_row(REG_MAX_ITER, 32'd1));
    dir_tab.push_back(pix_row(4000, 100, 1'b1, '{4000, 100, 0, 0, 0, 1}));
    dir_tab.push_back(pix_row(8191, 0, 1'b1, '{8191, 0, 0, 0, 0, 1}));
    dir_tab.push_back(cfg_row(REG_MAX_ITER, 32'd0));
    dir_tab.push_back(pix_row(123, 456, 1'b1, '{123, 456, 0, 0, 0, 0}));
    // Origin at its top value: pixels left of and above it map with negative offsets,
    // and the one at the window's centre of attraction runs the full 255 steps.
    dir_tab.push_back(cfg_row(REG_MAX_ITER, 32'd255));
    dir_tab.push_back(cfg_row(REG_ORIGIN_X, 32'd4095));
    dir_tab.push_back(cfg_row(REG_ORIGIN_Y, 32'd4095));
    dir_tab.push_back(pix_row(0, 0, 1'b0, '0));
    dir_tab.push_back(pix_row(4826, 4479, 1'b0, '0));
    // Zero dimensions act as one; the top of the field is held at the largest size.
    dir_tab.push_back(cfg_row(REG_WIDTH, 32'd0));
    dir_tab.push_back(cfg_row(REG_HEIGHT, 32'd0));
    dir_tab.push_back(pix_row(4095, 4095, 1'b0, '0));
    dir_tab.push_back(pix_row(4096, 4094, 1'b0, '0));
    dir_tab.push_back(cfg_row(REG_WIDTH, 32'd8191));
    dir_tab.push_back(cfg_row(REG_HEIGHT, 32'd8191));
    dir_tab.push_back(pix_row(8191, 8191, 1'b0, '0));
    dir_tab.push_back(pix_row(0, 8191, 1'b0, '0));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        want = dir_tab[i].typed ? dir_tab[i].result : compute_escape(dir_tab[i].pix);
        send_pixel(dir_tab[i].pix, want, 1'b1);
      end
    end

    // Random phases. Each starts from an idle block with a fresh setting of all six
    // registers. Most pixels fall inside the drawn window, where the escape counts
    // spread out; the rest cover the whole 13-bit range of both coordinates.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      cfg_write(REG_ORIGIN_X, pick_origin());
      cfg_write(REG_ORIGIN_Y, pick_origin());
      cfg_write(REG_WIDTH,    pick_dim());
      cfg_write(REG_HEIGHT,   pick_dim());
      cfg_write(REG_CHANNEL,  32'($urandom_range(3)));
      cfg_write(REG_MAX_ITER, pick_limit());
      for (k = 0; k < PHASE_PIXELS; k++) begin
        // Midway through a phase the sender waits for the block to empty completely.
        if (k == PHASE_PIXELS / 2) wait_drained();
        if ($urandom_range(9) < 2) begin
          p.pixel_col = COL_W'($urandom_range(8191));
          p.pixel_row = COL_W'($urandom_range(8191));
        end else begin
          p.pixel_col = COL_W'(int'(win_origin_x) + $urandom_range(eff_dim(win_width) - 1));
          p.pixel_row = COL_W'(int'(win_origin_y) + $urandom_range(eff_dim(win_height) - 1));
        end
        send_pixel(p, compute_escape(p), ph != CALM_PHASE);
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // Let every owed result arrive, then watch a while longer for strays.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d results never arrived", pending_pixels.size());
      n_errors++;
    end

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mep_pkg.sv
sv/mep_divlane.sv
sv/mep_datapath.sv
sv/mep_ctrl.sv
sv/mandelbrot_escape_pixel_top.sv
tb/sv/mandelbrot_escape_pixel_top_tb.sv
